// ===== rtl/multichannel_fir_lowpass_core_defines.svh =====
// Assertion macros shared by the checker of the multichannel FIR core.
// Both macros sample on aclk; the first one is also disabled while aresetn is low.
`ifndef MULTICHANNEL_FIR_LOWPASS_CORE_DEFINES_SVH
`define MULTICHANNEL_FIR_LOWPASS_CORE_DEFINES_SVH

`define MCFIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define MCFIR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/mcfir_pkg.sv =====
// Package for the multichannel FIR core: sizes, register indexes, opcodes.
// It has no dependencies.
package mcfir_pkg;

    localparam int MAX_TAPS     = 64;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int ACC_WIDTH    = 40;
    localparam int FRAC_BITS    = 15;

    localparam int TAP_COUNT_W  = 7;
    localparam int CHAN_COUNT_W = 4;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_ADDR_W   = 1;
    localparam int CHANNEL_W    = 3;
    localparam int COEF_IDX_W   = 6;

    localparam logic [TAP_COUNT_W-1:0]  TAP_COUNT_RESET  = 7'd32;
    localparam logic [CHAN_COUNT_W-1:0] CHAN_COUNT_RESET = 4'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_TAP_COUNT     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

endpackage

// ===== rtl/mcfir_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies.
module mcfir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/multichannel_fir_lowpass_core.sv =====
// Multichannel FIR filter core: one shared multiply-accumulate walks the taps.
// Depends on mcfir_pkg and mcfir_ram.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    opcode, channel, sample, coef index/value
//  m_       out        m_valid/m_ready    channel, filtered sample, saturated flag
//  cfg_     in         cfg_wr_en only     register index, write data
//
// A sample request is accepted and its sample written into the history; each tap
// then passes through the single multiply-accumulate (read, product register,
// accumulate), then the sum is rounded. Loads and unused channels keep the core idle.
// Reset and register writes empty the histories through per-channel fill counts.
// A result waits in the output register while the next request is accepted.
module multichannel_fir_lowpass_core #(
    parameter int MAX_TAPS     = mcfir_pkg::MAX_TAPS,
    parameter int MAX_CHANNELS = mcfir_pkg::MAX_CHANNELS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mcfir_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [mcfir_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_opcode,
    input  logic [mcfir_pkg::CHANNEL_W-1:0]     s_channel,
    input  logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] s_sample_in,
    input  logic [mcfir_pkg::COEF_IDX_W-1:0]    s_coef_index,
    input  logic signed [mcfir_pkg::COEF_WIDTH-1:0]   s_coef_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mcfir_pkg::CHANNEL_W-1:0]     m_channel_out,
    output logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] m_sample_out,
    output logic                                m_saturated
);

    localparam int SW      = mcfir_pkg::SAMPLE_WIDTH;
    localparam int CW      = mcfir_pkg::COEF_WIDTH;
    localparam int AccW    = mcfir_pkg::ACC_WIDTH;
    localparam int ProdW   = SW + CW;
    localparam int QW      = AccW + 1 - mcfir_pkg::FRAC_BITS;
    localparam int TAP_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W   = $clog2(MAX_TAPS + 1);
    localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HIST_DEPTH = MAX_CHANNELS * MAX_TAPS;
    localparam int HIST_AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;

    localparam logic signed [QW-1:0] Q_HI = QW'((1 << (SW - 1)) - 1);
    localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);
    localparam logic signed [AccW:0] ROUND_BIAS = (AccW + 1)'(1 << (mcfir_pkg::FRAC_BITS - 1));

    logic [1:0] state_reg, state_next;
    logic [mcfir_pkg::TAP_COUNT_W-1:0]  tap_count_reg;
    logic [mcfir_pkg::CHAN_COUNT_W-1:0] chan_count_reg;
    logic [TAP_W-1:0] head_reg [MAX_CHANNELS];
    logic [CNT_W-1:0] fill_reg [MAX_CHANNELS];
    logic [MAX_TAPS-1:0] coef_vld_reg;

    logic [HIST_AW-1:0] base_reg, base_next;
    logic [TAP_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] fill_cur_reg, fill_cur_next;
    logic [CNT_W-1:0] taps_reg, taps_next;
    logic issue_reg, issue_next;
    logic s1_vld_reg, s1_vld_next;
    logic s1_use_reg, s1_use_next;
    logic s1_last_reg, s1_last_next;
    logic p_vld_reg, p_vld_next;
    logic p_last_reg, p_last_next;
    logic signed [ProdW-1:0] prod_reg, prod_next;
    logic signed [AccW-1:0] acc_reg, acc_next;
    logic [mcfir_pkg::CHANNEL_W-1:0] chan_reg, chan_next;

    logic m_valid_reg, m_valid_next;
    logic [mcfir_pkg::CHANNEL_W-1:0] m_channel_reg;
    logic signed [SW-1:0] m_sample_reg;
    logic m_sat_reg;

    logic accept, is_load, coef_ok, chan_ok, start, cfg_clear, out_load, last_issue;
    int taps_eff, chans_eff;
    logic [CH_W-1:0] ch_idx;
    logic [TAP_W-1:0] head_sel, new_head;
    logic [CNT_W-1:0] fill_sel, new_fill;
    logic [HIST_AW-1:0] hist_waddr, hist_raddr;
    logic [SW-1:0] hist_rdata;
    logic [CW-1:0] coef_rdata;
    logic signed [AccW:0] biased;
    logic signed [QW-1:0] q;
    logic signed [SW-1:0] q_sat;
    logic q_clip;

    mcfir_ram #(.WIDTH(SW), .DEPTH(HIST_DEPTH)) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (start),
        .wr_addr (hist_waddr),
        .wr_data (s_sample_in),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    mcfir_ram #(.WIDTH(CW), .DEPTH(MAX_TAPS)) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (accept && is_load && coef_ok),
        .wr_addr (TAP_W'(s_coef_index)),
        .wr_data (s_coef_value),
        .rd_addr (cnt_reg[TAP_W-1:0]),
        .rd_data (coef_rdata)
    );

    always_comb begin
        if (tap_count_reg == '0) begin
            taps_eff = 1;
        end else if (int'(tap_count_reg) > MAX_TAPS) begin
            taps_eff = MAX_TAPS;
        end else begin
            taps_eff = int'(tap_count_reg);
        end
        if (chan_count_reg == '0) begin
            chans_eff = 1;
        end else if (int'(chan_count_reg) > MAX_CHANNELS) begin
            chans_eff = MAX_CHANNELS;
        end else begin
            chans_eff = int'(chan_count_reg);
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign is_load   = (s_opcode == mcfir_pkg::OP_LOAD);
    assign coef_ok   = int'(s_coef_index) < MAX_TAPS;
    assign chan_ok   = int'(s_channel) < chans_eff;
    assign start     = accept && !is_load && chan_ok;
    assign cfg_clear = cfg_wr_en && (cfg_index == mcfir_pkg::CFG_TAP_COUNT ||
                                     cfg_index == mcfir_pkg::CFG_CHANNEL_COUNT);

    assign ch_idx     = CH_W'(s_channel);
    assign head_sel   = head_reg[ch_idx];
    assign fill_sel   = fill_reg[ch_idx];
    assign new_head   = (head_sel == '0) ? TAP_W'(MAX_TAPS - 1) : head_sel - TAP_W'(1);
    assign new_fill   = (int'(fill_sel) == MAX_TAPS) ? fill_sel : fill_sel + CNT_W'(1);
    assign hist_waddr = HIST_AW'(int'(ch_idx) * MAX_TAPS + int'(new_head));
    assign hist_raddr = base_reg + HIST_AW'(ptr_reg);
    assign last_issue = (cnt_reg == taps_reg - CNT_W'(1));
    assign out_load   = (state_reg == ST_ROUND) && (!m_valid_reg || m_ready);

    assign biased = {acc_reg[AccW-1], acc_reg} + ROUND_BIAS;
    assign q      = biased[AccW:mcfir_pkg::FRAC_BITS];

    always_comb begin
        q_clip = 1'b0;
        q_sat  = SW'(q);
        if (q > Q_HI) begin
            q_clip = 1'b1;
            q_sat  = SW'(Q_HI);
        end else if (q < Q_LO) begin
            q_clip = 1'b1;
            q_sat  = SW'(Q_LO);
        end
    end

    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        fill_cur_next = fill_cur_reg;
        taps_next     = taps_reg;
        issue_next    = issue_reg;
        chan_next     = chan_reg;
        acc_next      = acc_reg;
        s1_vld_next   = 1'b0;
        s1_use_next   = 1'b0;
        s1_last_next  = 1'b0;
        p_vld_next    = s1_vld_reg;
        p_last_next   = s1_last_reg;
        prod_next     = '0;
        m_valid_next  = m_valid_reg && !m_ready;
        if (s1_use_reg) begin
            prod_next = ProdW'($signed(hist_rdata)) * ProdW'($signed(coef_rdata));
        end
        if (p_vld_reg) begin
            acc_next = acc_reg + AccW'(prod_reg);
        end
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next    = ST_RUN;
                    base_next     = HIST_AW'(int'(ch_idx) * MAX_TAPS);
                    ptr_next      = new_head;
                    cnt_next      = '0;
                    fill_cur_next = new_fill;
                    taps_next     = CNT_W'(taps_eff);
                    issue_next    = 1'b1;
                    chan_next     = s_channel;
                    acc_next      = '0;
                end
            end
            ST_RUN: begin
                if (issue_reg) begin
                    s1_vld_next  = 1'b1;
                    s1_use_next  = (cnt_reg < fill_cur_reg) && coef_vld_reg[cnt_reg[TAP_W-1:0]];
                    s1_last_next = last_issue;
                    issue_next   = !last_issue;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    ptr_next     = (int'(ptr_reg) == MAX_TAPS - 1) ? '0 : ptr_reg + TAP_W'(1);
                end
                if (p_vld_reg && p_last_reg) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (out_load) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tap_count_reg  <= mcfir_pkg::TAP_COUNT_RESET;
            chan_count_reg <= mcfir_pkg::CHAN_COUNT_RESET;
            coef_vld_reg   <= '0;
            issue_reg      <= 1'b0;
            s1_vld_reg     <= 1'b0;
            s1_last_reg    <= 1'b0;
            p_vld_reg      <= 1'b0;
            p_last_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            s1_vld_reg  <= s1_vld_next;
            s1_last_reg <= s1_last_next;
            p_vld_reg   <= p_vld_next;
            p_last_reg  <= p_last_next;
            m_valid_reg <= m_valid_next;
            if (accept && is_load && coef_ok) begin
                coef_vld_reg[TAP_W'(s_coef_index)] <= 1'b1;
            end
            if (cfg_wr_en && cfg_index == mcfir_pkg::CFG_TAP_COUNT) begin
                tap_count_reg <= cfg_wr_data[mcfir_pkg::TAP_COUNT_W-1:0];
            end
            if (cfg_wr_en && cfg_index == mcfir_pkg::CFG_CHANNEL_COUNT) begin
                chan_count_reg <= cfg_wr_data[mcfir_pkg::CHAN_COUNT_W-1:0];
            end
            if (cfg_clear) begin
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    head_reg[i] <= '0;
                    fill_reg[i] <= '0;
                end
            end else if (start) begin
                head_reg[ch_idx] <= new_head;
                fill_reg[ch_idx] <= new_fill;
            end
        end
    end

    always_ff @(posedge aclk) begin
        base_reg     <= base_next;
        ptr_reg      <= ptr_next;
        cnt_reg      <= cnt_next;
        fill_cur_reg <= fill_cur_next;
        taps_reg     <= taps_next;
        chan_reg     <= chan_next;
        acc_reg      <= acc_next;
        s1_use_reg   <= s1_use_next;
        prod_reg     <= prod_next;
        if (out_load) begin
            m_channel_reg <= chan_reg;
            m_sample_reg  <= q_sat;
            m_sat_reg     <= q_clip;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_reg;
    assign m_sample_out  = m_sample_reg;
    assign m_saturated   = m_sat_reg;

endmodule

// ===== rtl/mcfir_checker.sv =====
// Port-level checker for the multichannel FIR core, bound to the top level.
// Depends on mcfir_pkg and the assertion macros header.
`include "multichannel_fir_lowpass_core_defines.svh"

module mcfir_checker (
    input logic                                      aclk,
    input logic                                      aresetn,
    input logic                                      s_valid,
    input logic                                      s_ready,
    input logic                                      s_opcode,
    input logic [mcfir_pkg::CHANNEL_W-1:0]           s_channel,
    input logic                                      m_valid,
    input logic                                      m_ready,
    input logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] m_sample_out
);

    // Channel zero is always in use, so a sample on it starts the accumulation.
    `MCFIR_ASSERT(a_busy_after_sample, s_valid && s_ready && s_opcode == mcfir_pkg::OP_FILTER && s_channel == '0 |=> !s_ready, "sample request on channel zero did not make the core busy")
    `MCFIR_ASSERT(a_load_single_cycle, s_valid && s_ready && s_opcode == mcfir_pkg::OP_LOAD |=> s_ready, "coefficient load did not finish in one cycle")
    `MCFIR_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_sample_out), "stalled result changed or dropped")
    `MCFIR_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind multichannel_fir_lowpass_core mcfir_checker u_mcfir_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_opcode     (s_opcode),
    .s_channel    (s_channel),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);
